FILE: hdl/ftc_pkg.sv
// Package for the FIFO replacement tag cache.
// Holds sizes, status codes, controller states, the controller/datapath
// command and status structs and the key canonicalization function.
package ftc_pkg;

   localparam int ENTRIES   = 8;
   localparam int KEY_CHARS = 8;
   localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int KEY_W     = 64;
   localparam int KEY_BYTES = KEY_W / 8;
   localparam int STATUS_W  = 3;
   localparam int SLOT_W    = 3;

   typedef logic [KEY_W-1:0]    key_type;
   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [SLOT_W-1:0]   slot_type;

   localparam status_type ST_HIT         = 3'd0;
   localparam status_type ST_FILLED      = 3'd1;
   localparam status_type ST_FILL_FAILED = 3'd2;
   localparam status_type ST_REJECTED    = 3'd3;
   localparam status_type ST_CLEARED     = 3'd4;

   localparam logic ACT_LOOKUP = 1'b0;
   localparam logic ACT_CLEAR  = 1'b1;

   localparam idx_type IDX_LAST = idx_type'(ENTRIES - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECIDE,
      S_SCAN,
      S_MISS
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;        // capture the request
      logic scan_start;  // zero the scan index
      logic scan_adv;    // advance the scan index
      logic fill;        // replace the slot at the pointer
      logic wipe;        // invalidate all entries, zero the pointer
      logic rsp_hit;
      logic rsp_miss;
      logic rsp_clear;
      logic rsp_reject;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic is_clear;
      logic request_ok;
      logic match;
      logic scan_last;
   } stat_type;

   // Keep the low KEY_CHARS bytes up to the first zero byte.
   function automatic key_type canon_key(input key_type k);
      key_type res;
      logic    alive;
      res   = '0;
      alive = 1'b1;
      for (int i = 0; i < KEY_BYTES; i++) begin
         if (i < KEY_CHARS && alive && k[8*i +: 8] != 8'h00) begin
            res[8*i +: 8] = k[8*i +: 8];
         end else begin
            alive = 1'b0;
         end
      end
      return res;
   endfunction

   // Entry index masked to the result slot width
   function automatic slot_type to_slot(input idx_type idx);
      logic [IDX_W+SLOT_W-1:0] ext;
      ext = (IDX_W+SLOT_W)'(idx);
      return ext[SLOT_W-1:0];
   endfunction

endpackage

FILE: hdl/ftc_ctrl.sv
// Controller state machine for the FIFO replacement tag cache.
// Depends on ftc_pkg; drives the datapath through cmd_type, reads stat_type.
module ftc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ftc_pkg::stat_type stat,
   output ftc_pkg::cmd_type  cmd
);
   import ftc_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (stat.is_clear || !stat.request_ok) state_in = S_IDLE;
            else                                   state_in = S_SCAN;
         end
         S_SCAN: begin
            if (stat.match)          state_in = S_IDLE;
            else if (stat.scan_last) state_in = S_MISS;
         end
         S_MISS: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         S_DECIDE: begin
            cmd.scan_start = 1'b1;
            if (stat.is_clear) begin
               cmd.wipe      = 1'b1;
               cmd.rsp_clear = 1'b1;
            end else if (!stat.request_ok) begin
               cmd.rsp_reject = 1'b1;
            end
         end
         S_SCAN: begin
            if (stat.match) cmd.rsp_hit = 1'b1;
            else            cmd.scan_adv = 1'b1;
         end
         S_MISS: begin
            cmd.fill     = 1'b1;
            cmd.rsp_miss = 1'b1;
         end
         default: busy = 1'b1;
      endcase
   end

endmodule

FILE: hdl/ftc_dp.sv
// Datapath for the FIFO replacement tag cache: tag store, valid bits,
// replacement pointer, scan index and result register. Depends on ftc_pkg.
module ftc_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_action,
   input  ftc_pkg::key_type     req_sprite_key,
   input  logic                 req_request_ok,
   input  logic                 req_fill_ok,
   input  ftc_pkg::cmd_type     cmd,
   output ftc_pkg::stat_type    stat,
   output logic                 rsp_valid,
   output ftc_pkg::status_type  rsp_status,
   output ftc_pkg::slot_type    rsp_slot_index
);
   import ftc_pkg::*;

   key_type              key_mem [ENTRIES];
   key_type              key_rd_ff;
   logic [ENTRIES-1:0]   valid_ff;
   idx_type              ptr_ff;
   idx_type              scan_ff;
   idx_type              scan_in;
   key_type              key_ff;
   logic                 action_ff;
   logic                 req_ok_ff;
   logic                 fill_ok_ff;
   logic                 rsp_valid_ff;
   status_type           rsp_status_ff;
   slot_type             rsp_slot_ff;
   logic                 match;

   assign match = valid_ff[scan_ff] && (key_rd_ff == key_ff);

   assign stat.is_clear   = (action_ff == ACT_CLEAR);
   assign stat.request_ok = req_ok_ff;
   assign stat.match      = match;
   assign stat.scan_last  = (scan_ff == IDX_LAST);

   always_comb begin
      scan_in = scan_ff;
      if (cmd.scan_start)    scan_in = '0;
      else if (cmd.scan_adv) scan_in = scan_ff + 1'b1;
   end

   // Request capture, canonical key stored once
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff     <= canon_key(req_sprite_key);
         action_ff  <= req_action;
         req_ok_ff  <= req_request_ok;
         fill_ok_ff <= req_fill_ok;
      end
   end

   // Write the tag of a successful fill at the pointer; read the tag that the scan looks at next
   always_ff @(posedge clock) begin
      if (cmd.fill && fill_ok_ff) begin
         key_mem[ptr_ff] <= key_ff;
      end
      key_rd_ff <= key_mem[scan_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ptr_ff   <= '0;
         scan_ff  <= '0;
      end else begin
         if (cmd.wipe) begin
            valid_ff <= '0;
            ptr_ff   <= '0;
         end else if (cmd.fill) begin
            valid_ff[ptr_ff] <= fill_ok_ff;
            ptr_ff           <= (ptr_ff == IDX_LAST) ? '0 : ptr_ff + 1'b1;
         end
         scan_ff <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.rsp_hit | cmd.rsp_miss | cmd.rsp_clear | cmd.rsp_reject;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_hit) begin
         rsp_status_ff <= ST_HIT;
         rsp_slot_ff   <= to_slot(scan_ff);
      end else if (cmd.rsp_miss) begin
         rsp_status_ff <= fill_ok_ff ? ST_FILLED : ST_FILL_FAILED;
         rsp_slot_ff   <= to_slot(ptr_ff);
      end else if (cmd.rsp_clear) begin
         rsp_status_ff <= ST_CLEARED;
         rsp_slot_ff   <= '0;
      end else if (cmd.rsp_reject) begin
         rsp_status_ff <= ST_REJECTED;
         rsp_slot_ff   <= '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_slot_ff;

endmodule

FILE: hdl/fifo_replacement_tag_cache.sv
// Top level of the FIFO replacement tag cache: controller plus datapath.
// Depends on ftc_pkg, ftc_ctrl and ftc_dp.
//
//   channel   handshake            payload
//   request   start / busy         req_action, req_sprite_key, req_request_ok, req_fill_ok
//   result    rsp_valid (strobe)   rsp_status, rsp_slot_index
//
// A transaction is taken when start is high and busy is low; its result
// strobes for one cycle, one per transaction.
// Clear and rejected requests answer from the decide state; a hit answers when the scan
// finds the tag, a miss after the last tag and the fill: one tag is checked per cycle.
// Synchronous reset empties the directory and zeroes the replacement pointer.
// The receiver cannot stall; a new transaction is taken while a result strobes.
module fifo_replacement_tag_cache (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_action,
   input  ftc_pkg::key_type     req_sprite_key,
   input  logic                 req_request_ok,
   input  logic                 req_fill_ok,
   output logic                 rsp_valid,
   output ftc_pkg::status_type  rsp_status,
   output ftc_pkg::slot_type    rsp_slot_index
);
   import ftc_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   ftc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   ftc_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_action     (req_action),
      .req_sprite_key (req_sprite_key),
      .req_request_ok (req_request_ok),
      .req_fill_ok    (req_fill_ok),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_slot_index (rsp_slot_index)
   );

endmodule

FILE: hdl/ftc_checker.sv
// Port-level checker for the FIFO replacement tag cache, bound to the top.
// Depends on ftc_pkg.
module ftc_checker (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                req_action,
   input logic                rsp_valid,
   input ftc_pkg::status_type rsp_status,
   input ftc_pkg::slot_type   rsp_slot_index
);
   import ftc_pkg::*;

   // An accepted transaction occupies the block in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low after an accepted transaction");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_CLEARED))
      else $error("result status out of range");

   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_REJECTED || rsp_status == ST_CLEARED))
         |-> (rsp_slot_index == '0))
      else $error("nonzero slot on rejected or cleared result");

   // A clear answers once it has passed the decide state and the result register
   a_clear_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action == ACT_CLEAR)
         |-> ##2 (rsp_valid && rsp_status == ST_CLEARED))
      else $error("clear result missing");

   // No result without a transaction in flight the cycle before
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a transaction");

endmodule

bind fifo_replacement_tag_cache ftc_checker u_ftc_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_action     (req_action),
   .rsp_valid      (rsp_valid),
   .rsp_status     (rsp_status),
   .rsp_slot_index (rsp_slot_index)
);

FILE: test/fifo_replacement_tag_cache_tb.sv
// Testbench for fifo_replacement_tag_cache: directed and random lookups and clears,
// each result checked against a behavioral model of the tag directory.
// Depends on ftc_pkg and the fifo_replacement_tag_cache RTL.
`timescale 1ns / 100ps

module fifo_replacement_tag_cache_tb;
   import ftc_pkg::*;

   localparam int POOL_SIZE = 12;

   typedef struct {
      status_type status;
      slot_type   slot;
   } cache_rsp_type;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       start          = 1'b0;
   logic       busy;
   logic       req_action     = ACT_LOOKUP;
   key_type    req_sprite_key = '0;
   logic       req_request_ok = 1'b0;
   logic       req_fill_ok    = 1'b0;
   logic       rsp_valid;
   status_type rsp_status;
   slot_type   rsp_slot_index;

   // Model of the tag directory
   key_type    dir_key   [ENTRIES];
   logic       dir_valid [ENTRIES];
   int         dir_ptr;

   cache_rsp_type pending_rsp[$];
   int         mismatches = 0;
   int         idle_pct   = 0;

   // Keys that recur, so that lookups hit as well as evict
   key_type    pool_key [POOL_SIZE];
   int         pool_len [POOL_SIZE];

   fifo_replacement_tag_cache dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_sprite_key (req_sprite_key),
      .req_request_ok (req_request_ok),
      .req_fill_ok    (req_fill_ok),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_slot_index (rsp_slot_index)
   );

   always #6 clock = ~clock;

   // Keep the low KEY_CHARS bytes up to the first zero byte.
   function automatic key_type trim_key(input key_type raw);
      key_type kept;
      kept = '0;
      for (int b = 0; b < KEY_CHARS; b++) begin
         if (raw[8*b +: 8] == 8'h00) break;
         kept[8*b +: 8] = raw[8*b +: 8];
      end
      return kept;
   endfunction

   function automatic void flush_directory();
      for (int i = 0; i < ENTRIES; i++) dir_valid[i] = 1'b0;
      dir_ptr = 0;
   endfunction

   function automatic cache_rsp_type predict_access(input logic act, input key_type key,
                                                    input logic req_ok, input logic fill_ok);
      cache_rsp_type res;
      key_type    tag;
      int         victim;
      if (act == ACT_CLEAR) begin
         flush_directory();
         res.status = ST_CLEARED;
         res.slot   = '0;
         return res;
      end
      if (!req_ok) begin
         res.status = ST_REJECTED;
         res.slot   = '0;
         return res;
      end
      tag = trim_key(key);
      for (int i = 0; i < ENTRIES; i++) begin
         if (dir_valid[i] && dir_key[i] == tag) begin
            res.status = ST_HIT;
            res.slot   = slot_type'(i);
            return res;
         end
      end
      victim           = dir_ptr;
      dir_ptr          = (victim + 1) % ENTRIES;
      dir_valid[victim] = 1'b0;
      if (fill_ok) begin
         dir_key[victim]   = tag;
         dir_valid[victim] = 1'b1;
         res.status        = ST_FILLED;
      end else begin
         res.status = ST_FILL_FAILED;
      end
      res.slot = slot_type'(victim);
      return res;
   endfunction

   // Put random garbage above the terminating zero byte of a short key.
   function automatic key_type dress_key(input key_type base, input int len);
      key_type raw;
      raw = base;
      if (len < 8) begin
         raw[8*len +: 8] = 8'h00;
         for (int b = len + 1; b < 8; b++) begin
            raw[8*b +: 8] = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
         end
      end
      return raw;
   endfunction

   function automatic void refresh_pool(input int idx);
      int      len;
      key_type base;
      case ($urandom_range(0, 9))
         0:             len = 0;
         1, 2, 3, 4, 5: len = $urandom_range(1, 3);
         default:       len = $urandom_range(4, 8);
      endcase
      base = '0;
      for (int b = 0; b < len; b++) begin
         // a narrow alphabet makes keys that share prefixes
         if ($urandom_range(0, 1) == 0) base[8*b +: 8] = 8'h41 + 8'($urandom_range(0, 2));
         else                           base[8*b +: 8] = 8'($urandom_range(1, 255));
      end
      pool_key[idx] = base;
      pool_len[idx] = len;
   endfunction

   task automatic idle_cycles(input int n);
      @(negedge clock);
      start          <= 1'b0;
      req_action     <= 1'($urandom_range(0, 1));
      req_sprite_key <= {$urandom, $urandom};
      req_request_ok <= 1'($urandom_range(0, 1));
      req_fill_ok    <= 1'($urandom_range(0, 1));
      repeat (n) @(posedge clock);
   endtask

   // Present one transaction and hold it until the block takes it.
   task automatic issue_access(input logic act, input key_type key,
                               input logic req_ok, input logic fill_ok);
      cache_rsp_type want;
      if ($urandom_range(0, 99) < idle_pct) idle_cycles($urandom_range(1, 17));
      @(negedge clock);
      start          <= 1'b1;
      req_action     <= act;
      req_sprite_key <= key;
      req_request_ok <= req_ok;
      req_fill_ok    <= fill_ok;
      @(posedge clock);
      while (busy) @(posedge clock);
      want = predict_access(act, key, req_ok, fill_ok);
      pending_rsp.push_back(want);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic test_clear_and_reject();
      issue_access(ACT_CLEAR, '1, 1'b0, 1'b0);
      issue_access(ACT_LOOKUP, '1, 1'b0, 1'b1);
      wait_drained();
   endtask

   task automatic test_fill_and_hit();
      // two-character keys fill every slot, then the pointer wraps
      for (int i = 0; i < ENTRIES; i++) begin
         issue_access(ACT_LOOKUP, 64'h3000 | 64'(8'h61 + i), 1'b1, 1'b1);
      end
      issue_access(ACT_LOOKUP, 64'h7A, 1'b1, 1'b1);
      issue_access(ACT_LOOKUP, 64'h3000 | 64'(8'h61 + 7), 1'b1, 1'b1);
      issue_access(ACT_LOOKUP, 64'h3000 | 64'(8'h61 + 1), 1'b1, 1'b1);
      wait_drained();
   endtask

   task automatic test_failed_fill();
      issue_access(ACT_LOOKUP, 64'h77, 1'b1, 1'b0);
      issue_access(ACT_LOOKUP, 64'h77, 1'b1, 1'b1);
      issue_access(ACT_LOOKUP, 64'h3000 | 64'(8'h61 + 7), 1'b0, 1'b1);
      wait_drained();
   endtask

   task automatic test_key_forms();
      issue_access(ACT_LOOKUP, 64'hDEAD_BEEF_0123_4500, 1'b1, 1'b1);
      issue_access(ACT_LOOKUP, 64'h0, 1'b1, 1'b1);
      issue_access(ACT_LOOKUP, 64'hC3FF_1200_0000_4241, 1'b1, 1'b1);
      issue_access(ACT_LOOKUP, 64'h0000_0000_0000_4241, 1'b1, 1'b1);
      issue_access(ACT_LOOKUP, '1, 1'b1, 1'b1);
      issue_access(ACT_LOOKUP, '1, 1'b1, 1'b0);
      issue_access(ACT_LOOKUP, 64'h00FF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
      wait_drained();
   endtask

   task automatic test_clear();
      issue_access(ACT_CLEAR, 64'h4241, 1'b0, 1'b1);
      issue_access(ACT_LOOKUP, 64'h4241, 1'b1, 1'b1);
      wait_drained();
   endtask

   task automatic test_random_traffic();
      int      r;
      int      pick;
      key_type key;
      for (int p = 0; p < POOL_SIZE; p++) refresh_pool(p);
      for (int n = 0; n < 1300; n++) begin
         // idle in bursty stretches, none at the tail
         if (n >= 1150)         idle_pct = 0;
         else if (n % 100 == 0) idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 35;
         if ($urandom_range(0, 49) == 0) refresh_pool($urandom_range(0, POOL_SIZE - 1));
         pick = $urandom_range(0, POOL_SIZE - 1);
         if ($urandom_range(0, 9) == 0) key = {$urandom, $urandom};
         else                           key = dress_key(pool_key[pick], pool_len[pick]);
         r = $urandom_range(0, 99);
         if (r < 3)       issue_access(ACT_CLEAR, {$urandom, $urandom},
                                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         else if (r < 12) issue_access(ACT_LOOKUP, key, 1'b0, 1'($urandom_range(0, 1)));
         else             issue_access(ACT_LOOKUP, key, 1'b1, $urandom_range(0, 9) != 0);
      end
      wait_drained();
   endtask

   // Compare each strobed result with the oldest expectation.
   always @(posedge clock) begin
      cache_rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected result: rsp_status %0d rsp_slot_index %0d",
                   rsp_status, rsp_slot_index);
            mismatches++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_status !== want.status) begin
               $error("rsp_status expected %0d actual %0d", want.status, rsp_status);
               mismatches++;
            end
            if (rsp_slot_index !== want.slot) begin
               $error("rsp_slot_index expected %0d actual %0d", want.slot, rsp_slot_index);
               mismatches++;
            end
         end
      end
   end

   initial begin
      flush_directory();
      for (int i = 0; i < ENTRIES; i++) dir_key[i] = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      idle_pct = 30;
      test_clear_and_reject();
      test_fill_and_hit();
      test_failed_fill();
      test_key_forms();
      test_clear();
      test_random_traffic();

      repeat (24) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("** fifo_replacement_tag_cache: PASSED **");
      end else begin
         $display("** fifo_replacement_tag_cache: FAILED **");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("** fifo_replacement_tag_cache: FAILED **");
      $finish;
   end

endmodule
